// ----- rtl/core/lfr_pkg.sv -----
package lfr_pkg;

    // Ring geometry of one stream
    localparam int RING_LEN = 55;
    localparam int FAR_LAG  = 24;
    localparam int PTR_W    = 6;
    localparam logic [PTR_W-1:0] PTR_TOP = 6'd54;

    // Lanes of one ring entry
    localparam int LANES  = 4;
    localparam int LANE_W = 16;
    localparam int WORD_W = LANES * LANE_W;

    // Seeding
    localparam int SEED_W = 32;
    localparam logic [SEED_W-1:0] SEED_MULT = 32'd3141592621;

    // Stream selection
    localparam int STREAMS_DEF = 32;
    localparam int STREAM_W    = 5;
    localparam int SEL_EXT_W   = 9;

    // Stream bus widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    // Command codes carried in tuser
    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

endpackage

// ----- rtl/core/lfr_ring_mem.sv -----
module lfr_ring_mem #(
    parameter int DEPTH  = 1760,
    parameter int ADDR_W = 11
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr_a,
    input  logic [ADDR_W-1:0]          rd_addr_b,
    output logic [lfr_pkg::WORD_W-1:0] rd_data_a,
    output logic [lfr_pkg::WORD_W-1:0] rd_data_b,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [lfr_pkg::WORD_W-1:0] wr_data
);
    import lfr_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    // Synchronous write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two synchronous read ports; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- rtl/core/lfr_seeder.sv -----
module lfr_seeder #(
    parameter int STREAMS = lfr_pkg::STREAMS_DEF,
    parameter int IDX_W   = 5,
    parameter int ADDR_W  = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lfr_pkg::SEED_W-1:0] seed,
    output logic                       busy,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output logic [lfr_pkg::WORD_W-1:0] wr_data
);
    import lfr_pkg::*;

    logic                     busy_reg;
    logic                     busy_next;
    logic [1:0]               lane_reg;
    logic [PTR_W-1:0]         entry_reg;
    logic [IDX_W-1:0]         strm_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [SEED_W-1:0]        s_reg;
    logic [SEED_W-1:0]        s_next;
    logic [SEED_W-1:0]        base_reg;
    logic [WORD_W-LANE_W-1:0] word_reg;
    logic                     entry_done;
    logic                     stream_done;
    logic                     last_stream;

    assign entry_done  = (lane_reg == 2'd3);
    assign stream_done = entry_done && (entry_reg == PTR_TOP);
    assign last_stream = (strm_reg == IDX_W'(STREAMS - 1));

    // A new stream starts from base plus its index; otherwise step the LCG.
    always_comb
    begin
        if (stream_done)
        begin
            s_next = base_reg + SEED_W'(strm_reg) + 32'd1;
        end
        else
        begin
            s_next = SEED_W'((s_reg + 32'd1) * SEED_MULT);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && stream_done && last_stream)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            lane_reg  <= 2'd0;
            entry_reg <= '0;
            strm_reg  <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (start)
            begin
                lane_reg  <= 2'd0;
                entry_reg <= '0;
                strm_reg  <= '0;
                addr_reg  <= '0;
            end
            else if (busy_reg)
            begin
                lane_reg <= lane_reg + 2'd1;
                if (entry_done)
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (stream_done)
                    begin
                        entry_reg <= '0;
                        strm_reg  <= strm_reg + IDX_W'(1);
                    end
                    else
                    begin
                        entry_reg <= entry_reg + PTR_W'(1);
                    end
                end
            end
        end
    end

    // The last lane goes straight from s_reg into the write data.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg    <= seed;
            base_reg <= seed;
        end
        else if (busy_reg)
        begin
            s_reg <= s_next;
            if (!entry_done)
            begin
                word_reg[lane_reg*LANE_W +: LANE_W] <= s_reg[SEED_W-1 -: LANE_W];
            end
        end
    end

    assign busy    = busy_reg;
    assign wr_en   = busy_reg && entry_done;
    assign wr_addr = addr_reg;
    assign wr_data = {s_reg[SEED_W-1 -: LANE_W], word_reg};

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy_reg)
        else $error("seeder writes the ring while idle");

endmodule

// ----- rtl/core/lfr_draw.sv -----
module lfr_draw #(
    parameter int STREAMS = lfr_pkg::STREAMS_DEF,
    parameter int IDX_W   = 5,
    parameter int ADDR_W  = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ptr_clr,
    input  logic                            start,
    input  logic [IDX_W-1:0]                start_idx,
    output logic                            busy,
    output logic                            rd_en,
    output logic [ADDR_W-1:0]               rd_addr_a,
    output logic [ADDR_W-1:0]               rd_addr_b,
    input  logic [lfr_pkg::WORD_W-1:0]      rd_data_a,
    input  logic [lfr_pkg::WORD_W-1:0]      rd_data_b,
    output logic                            wr_en,
    output logic [ADDR_W-1:0]               wr_addr,
    output logic [lfr_pkg::WORD_W-1:0]      wr_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lfr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lfr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [PTR_W-1:0]   ptr_mem [STREAMS];
    logic [STREAMS-1:0] ptr_vld_reg;
    logic [PTR_W-1:0]   ptr_q_reg;
    logic               vld_q_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [PTR_W-1:0]   k_cur;
    logic [PTR_W-1:0]   j_cur;
    logic [PTR_W-1:0]   k_reg;
    logic [PTR_W-1:0]   k_dec;
    logic [ADDR_W-1:0]  addr_k_reg;
    logic [WORD_W-1:0]  sum;
    logic               out_free;
    logic               retire;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_data_reg;

    // An invalid pointer reads as the top of the ring.
    always_comb
    begin
        if (!vld_q_reg || (ptr_q_reg > PTR_TOP))
        begin
            k_cur = PTR_TOP;
        end
        else
        begin
            k_cur = ptr_q_reg;
        end
        if (k_cur < PTR_W'(RING_LEN - FAR_LAG))
        begin
            j_cur = k_cur + PTR_W'(FAR_LAG);
        end
        else
        begin
            j_cur = k_cur - PTR_W'(RING_LEN - FAR_LAG);
        end
    end

    assign k_dec    = (k_reg == '0) ? PTR_TOP : (k_reg - PTR_W'(1));
    assign out_free = !out_valid_reg || m_tready;
    assign retire   = (state_reg == ST_SUM) && out_free;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sum[l*LANE_W +: LANE_W] = rd_data_a[l*LANE_W +: LANE_W]
                                    + rd_data_b[l*LANE_W +: LANE_W];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ptr_clr)
            begin
                ptr_vld_reg <= '0;
            end
            else if (retire)
            begin
                ptr_vld_reg[idx_reg] <= 1'b1;
            end
            if (retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pointer store: read at accept, written when the draw retires.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ptr_q_reg <= ptr_mem[start_idx];
        end
        if (retire)
        begin
            ptr_mem[idx_reg] <= k_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vld_q_reg <= ptr_vld_reg[start_idx];
            idx_reg   <= start_idx;
            base_reg  <= ADDR_W'(start_idx * RING_LEN);
        end
        if (state_reg == ST_ADDR)
        begin
            k_reg      <= k_cur;
            addr_k_reg <= base_reg + ADDR_W'(k_cur);
        end
        if (retire)
        begin
            out_data_reg <= sum;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rd_en     = (state_reg == ST_ADDR);
    assign rd_addr_a = base_reg + ADDR_W'(k_cur);
    assign rd_addr_b = base_reg + ADDR_W'(j_cur);
    assign wr_en     = retire;
    assign wr_addr   = addr_k_reg;
    assign wr_data   = sum;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> out_valid_reg)
        else $error("retired draw did not reach the output register");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (k_reg <= PTR_TOP))
        else $error("ring pointer out of range");

endmodule

// ----- rtl/core/lagged_fibonacci_rng_multi_stream_core.sv -----
// Multi-stream additive lagged-Fibonacci generator, lags 24 and 55.
// Input channel (s_*): one transaction is one command. s_tuser[0] selects the
// command: 0 reseeds every stream from s_tdata[31:0] (stream i from seed + i),
// 1 draws from the stream in s_tdata[36:32]. A draw from a stream index at or
// above STREAMS is taken and dropped without a result.
// Output channel (m_*): one transaction per draw, four 16-bit fractions.
// All ring words live in one memory with two read ports and one write port;
// the per-stream pointers live in a small synchronous memory beside it.
// A draw runs in steps: pointer read at accept, two ring reads, then the lane
// sums are written back and loaded into the output register. The next command
// is taken in the cycle after that, so a draw is not taken before the last one
// retires. The output register frees the input side while a result waits.
// A reseed makes one seed step per lane and one ring write every four steps;
// no command is taken while it runs. Reset clears the control state and marks
// every pointer as the top of the ring; ring contents are undefined until the
// first reseed, so draws must follow a reseed. When the sink stalls, the result
// waits in the output register and one more command is taken; a draw then waits
// in its final step with its sums held, and no further command is taken.
module lagged_fibonacci_rng_multi_stream_core #(
    parameter int STREAMS = lfr_pkg::STREAMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields, low bit up: seed_value[31:0], stream[36:32], zero pad
    input  logic [lfr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser fields: cmd[0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields, low bit up: lane0, lane1, lane2, lane3
    output logic [lfr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lfr_pkg::*;

    localparam int IDX_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int DEPTH  = STREAMS * RING_LEN;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                 in_fire;
    logic                 cmd;
    logic [SEED_W-1:0]    seed;
    logic [SEL_EXT_W-1:0] sel_ext;
    logic                 in_range;
    logic                 seed_start;
    logic                 draw_start;

    logic                 seed_busy;
    logic                 seed_wr_en;
    logic [ADDR_W-1:0]    seed_wr_addr;
    logic [WORD_W-1:0]    seed_wr_data;

    logic                 draw_busy;
    logic                 draw_rd_en;
    logic [ADDR_W-1:0]    draw_rd_addr_a;
    logic [ADDR_W-1:0]    draw_rd_addr_b;
    logic [WORD_W-1:0]    ring_rd_data_a;
    logic [WORD_W-1:0]    ring_rd_data_b;
    logic                 draw_wr_en;
    logic [ADDR_W-1:0]    draw_wr_addr;
    logic [WORD_W-1:0]    draw_wr_data;

    logic                 ring_wr_en;
    logic [ADDR_W-1:0]    ring_wr_addr;
    logic [WORD_W-1:0]    ring_wr_data;

    // Commands are taken only while neither sequencer is working.
    assign s_tready = !seed_busy && !draw_busy;
    assign in_fire  = s_tvalid && s_tready;
    assign cmd      = s_tuser[0];
    assign seed     = s_tdata[SEED_W-1:0];
    assign sel_ext  = SEL_EXT_W'(s_tdata[SEED_W +: STREAM_W]);
    assign in_range = (sel_ext < SEL_EXT_W'(STREAMS));

    assign seed_start = in_fire && (cmd == CMD_RESEED);
    assign draw_start = in_fire && (cmd == CMD_DRAW) && in_range;

    // The seeder and the draw sequencer never write in the same cycle.
    assign ring_wr_en   = seed_wr_en || draw_wr_en;
    assign ring_wr_addr = seed_busy ? seed_wr_addr : draw_wr_addr;
    assign ring_wr_data = seed_busy ? seed_wr_data : draw_wr_data;

    lfr_ring_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring_mem (
        .clk       (clk),
        .rd_en     (draw_rd_en),
        .rd_addr_a (draw_rd_addr_a),
        .rd_addr_b (draw_rd_addr_b),
        .rd_data_a (ring_rd_data_a),
        .rd_data_b (ring_rd_data_b),
        .wr_en     (ring_wr_en),
        .wr_addr   (ring_wr_addr),
        .wr_data   (ring_wr_data)
    );

    lfr_seeder #(
        .STREAMS (STREAMS),
        .IDX_W   (IDX_W),
        .ADDR_W  (ADDR_W)
    ) u_seeder (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (seed_start),
        .seed    (seed),
        .busy    (seed_busy),
        .wr_en   (seed_wr_en),
        .wr_addr (seed_wr_addr),
        .wr_data (seed_wr_data)
    );

    lfr_draw #(
        .STREAMS (STREAMS),
        .IDX_W   (IDX_W),
        .ADDR_W  (ADDR_W)
    ) u_draw (
        .clk       (clk),
        .rst_n     (rst_n),
        .ptr_clr   (seed_start),
        .start     (draw_start),
        .start_idx (sel_ext[IDX_W-1:0]),
        .busy      (draw_busy),
        .rd_en     (draw_rd_en),
        .rd_addr_a (draw_rd_addr_a),
        .rd_addr_b (draw_rd_addr_b),
        .rd_data_a (ring_rd_data_a),
        .rd_data_b (ring_rd_data_b),
        .wr_en     (draw_wr_en),
        .wr_addr   (draw_wr_addr),
        .wr_data   (draw_wr_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(seed_wr_en && draw_wr_en))
        else $error("two writers on the ring memory");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(seed_busy && draw_busy))
        else $error("reseed and draw overlap");

    a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
        draw_start |=> draw_busy)
        else $error("accepted draw did not start");

    a_seed_starts: assert property (@(posedge clk) disable iff (!rst_n)
        seed_start |=> seed_busy)
        else $error("accepted reseed did not start");

endmodule
